[hdl/zrd_pkg.sv]
// Shared types and constants of the zero-run decoder.
`timescale 1ns / 1ps
`default_nettype none
package zrd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 3;

  localparam logic [BYTE_W-1:0]  ZERO_MARKER      = 8'h00;
  localparam logic [COUNT_W-1:0] CAPACITY_DEFAULT = 16'hFFFF;

  // Register index taken from the word address bit of paddr, its top bit.
  localparam logic REG_OUT_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_DANGLING  = 2'd1,
    STATUS_TRUNCATED = 2'd2
  } status_t;

  typedef struct packed {
    logic               armed;
    logic [COUNT_W-1:0] written;
    logic               overflowed;
  } zrd_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  value;
    logic [BYTE_W-1:0]  run;
    logic               final_word;
    logic [COUNT_W-1:0] length;
    status_t            status;
  } zrd_result_t;

endpackage
`default_nettype wire

[hdl/zrd_cfg.sv]
// APB register block holding the output capacity.
`timescale 1ns / 1ps
`default_nettype none
module zrd_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [zrd_pkg::APB_AW-1:0]   paddr,
  input  wire logic [zrd_pkg::APB_DW-1:0]   pwdata,
  output logic      [zrd_pkg::APB_DW-1:0]   prdata,
  output logic                              pready,
  output logic      [zrd_pkg::COUNT_W-1:0]  capacity
);
  import zrd_pkg::*;

  logic reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_AW-1] == REG_OUT_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_DEFAULT;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      capacity <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = {{(APB_DW-COUNT_W){1'b0}}, capacity};
    end
  end

endmodule
`default_nettype wire

[hdl/zrd_step.sv]
// Decode logic for one byte: next message state and the result word.
`timescale 1ns / 1ps
`default_nettype none
module zrd_step (
  input  wire logic [zrd_pkg::BYTE_W-1:0]  in_byte,
  input  wire logic                        in_last,
  input  wire logic [zrd_pkg::COUNT_W-1:0] capacity,
  input  wire zrd_pkg::zrd_state_t         state,
  output zrd_pkg::zrd_state_t              state_next,
  output logic                             emit,
  output zrd_pkg::zrd_result_t             result
);
  import zrd_pkg::*;

  logic [COUNT_W-1:0] room;
  logic [COUNT_W-1:0] room_after;
  logic [BYTE_W-1:0]  run;
  logic [BYTE_W-1:0]  value;
  logic               dangling;
  zrd_state_t         upd;

  // A capacity lowered below the written count leaves no room at all.
  assign room = (state.written >= capacity) ? '0 : (capacity - state.written);

  always_comb begin
    upd        = state;
    run        = '0;
    value      = '0;
    dangling   = 1'b0;
    room_after = room;
    if (state.armed) begin
      if (in_byte != ZERO_MARKER) begin
        if ({{(COUNT_W-BYTE_W){1'b0}}, in_byte} > room) begin
          run            = room[BYTE_W-1:0];
          upd.overflowed = 1'b1;
        end else begin
          run = in_byte;
        end
        upd.armed = 1'b0;
      end else begin
        if (room != '0) begin
          run        = {{(BYTE_W-1){1'b0}}, 1'b1};
          room_after = room - {{(COUNT_W-1){1'b0}}, 1'b1};
        end
        // A zero count is taken again as a marker, which needs room too.
        if (room_after == '0) begin
          upd.overflowed = 1'b1;
          upd.armed      = 1'b0;
        end else begin
          dangling = 1'b1;
        end
      end
    end else if (room == '0) begin
      upd.overflowed = 1'b1;
    end else if (in_byte == ZERO_MARKER) begin
      upd.armed = 1'b1;
      dangling  = 1'b1;
    end else begin
      value = in_byte;
      run   = {{(BYTE_W-1){1'b0}}, 1'b1};
    end
    upd.written = state.written + {{(COUNT_W-BYTE_W){1'b0}}, run};
  end

  always_comb begin
    emit              = in_last || (run != '0);
    result.value      = value;
    result.run        = run;
    result.final_word = in_last;
    result.length     = '0;
    result.status     = STATUS_OK;
    state_next        = upd;
    if (in_last) begin
      result.length = upd.written;
      if (upd.overflowed) begin
        result.status = STATUS_TRUNCATED;
      end else if (dangling) begin
        result.status = STATUS_DANGLING;
      end
      state_next = '0;
    end
  end

endmodule
`default_nettype wire

[hdl/zero_run_decoder.sv]
// Top level of the zero-run decoder: input register, message state and result register.
//
// Usage: encoded bytes enter on in_valid/in_ready with in_byte and in_last. Each
// accepted word yields at most one result word on out_valid/out_ready: a run of
// run_length copies of out_value, and on the message's last byte also is_final,
// decoded_length and status. A byte that produces no run and is not last gives
// no result word.
// A byte is first held in the input register and, once the result register is free
// or being emptied, is decoded into the result register, from which the receiver
// takes the word.
// Throughput: one byte per cycle while the receiver does not stall; the message
// state is a flag, a 16-bit count and an overflow flag, updated for each byte.
// The APB port holds out_capacity at address 0; write it only while idle.
// Reset clears both registers' valid flags and the message state, and sets the
// capacity to 65535. When the receiver stalls, the result register holds its
// word, the input register holds the next byte, and in_ready falls once both
// are full.
`timescale 1ns / 1ps
`default_nettype none
module zero_run_decoder (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [zrd_pkg::BYTE_W-1:0]   in_byte,
  input  wire logic                         in_last,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [zrd_pkg::BYTE_W-1:0]   out_value,
  output logic      [zrd_pkg::BYTE_W-1:0]   run_length,
  output logic                              is_final,
  output logic      [zrd_pkg::COUNT_W-1:0]  decoded_length,
  output zrd_pkg::status_t                  status,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [zrd_pkg::APB_AW-1:0]   paddr,
  input  wire logic [zrd_pkg::APB_DW-1:0]   pwdata,
  output logic      [zrd_pkg::APB_DW-1:0]   prdata,
  output logic                              pready
);
  import zrd_pkg::*;

  logic               capacity;
  logic [COUNT_W-1:0] out_capacity;
  logic               byte_valid;
  logic [BYTE_W-1:0]  byte_q;
  logic               last_q;
  logic               advance;
  logic               emit;
  zrd_state_t         msg_state;
  zrd_state_t         msg_state_next;
  zrd_result_t        result;
  zrd_result_t        result_q;

  zrd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (out_capacity)
  );

  zrd_step u_step (
    .in_byte    (byte_q),
    .in_last    (last_q),
    .capacity   (out_capacity),
    .state      (msg_state),
    .state_next (msg_state_next),
    .emit       (emit),
    .result     (result)
  );

  // The held byte moves on once the result register is free or being emptied.
  assign capacity = !out_valid || out_ready;
  assign advance  = byte_valid && capacity;
  assign in_ready = !byte_valid || capacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_q <= in_byte;
      last_q <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_state <= '0;
    end else if (advance) begin
      msg_state <= msg_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result_q <= result;
    end
  end

  assign out_value      = result_q.value;
  assign run_length     = result_q.run;
  assign is_final       = result_q.final_word;
  assign decoded_length = result_q.length;
  assign status         = result_q.status;

endmodule
`default_nettype wire

[tb/tb_zero_run_decoder.sv]
// Self-checking testbench for the zero-run decoder: random and directed messages.
`timescale 1ns / 1ps
module tb_zero_run_decoder;
  import zrd_pkg::*;

  localparam int unsigned LATENCY_CYCLES = 4;
  localparam int unsigned LONG_STALL     = 300;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam logic [APB_AW-1:0] CAPACITY_ADDR = '0;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } enc_word_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   in_byte = '0;
  logic                in_last = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [BYTE_W-1:0]   out_value;
  logic [BYTE_W-1:0]   run_length;
  logic                is_final;
  logic [COUNT_W-1:0]  decoded_length;
  status_t             status;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // Stimulus and expectations.
  enc_word_t   byte_queue[$];
  zrd_result_t expected_runs[$];
  int unsigned error_count = 0;
  int unsigned send_gap_pct = 35;
  int unsigned recv_gap_pct = 70;
  logic        stall_request = 1'b0;
  logic        recv_stall = 1'b0;

  // Decoder state as the testbench sees it.
  logic [COUNT_W-1:0] capacity_now = CAPACITY_DEFAULT;
  logic               armed = 1'b0;
  int unsigned        written = 0;
  logic               overflowed = 1'b0;

  zero_run_decoder u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .run_length     (run_length),
    .is_final       (is_final),
    .decoded_length (decoded_length),
    .status         (status),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("%0t ERROR %s", $realtime, msg);
    end
  endfunction

  function automatic int unsigned space_left();
    return (written >= capacity_now) ? 0 : capacity_now - written;
  endfunction

  // Works out the word that one accepted byte produces, if any.
  function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic last);
    zrd_result_t r;
    int unsigned room;
    int unsigned run;
    logic        dangling;
    r = '0;
    run = 0;
    dangling = 1'b0;
    room = space_left();
    if (armed) begin
      if (b != ZERO_MARKER) begin
        run = b;
        if (run > room) begin
          run = room;
          overflowed = 1'b1;
        end
        written += run;
        armed = 1'b0;
      end else begin
        // A count of zero writes one zero and stays armed, unless that filled the output.
        if (room > 0) begin
          run = 1;
          written += 1;
        end
        if (space_left() == 0) begin
          overflowed = 1'b1;
          armed = 1'b0;
        end else begin
          dangling = 1'b1;
        end
      end
    end else if (room == 0) begin
      overflowed = 1'b1;
    end else if (b == ZERO_MARKER) begin
      armed = 1'b1;
      dangling = 1'b1;
    end else begin
      r.value = b;
      run = 1;
      written += 1;
    end
    if (!last && run == 0) return;
    r.run = 8'(run);
    r.final_word = last;
    if (last) begin
      if (overflowed) begin
        r.status = STATUS_TRUNCATED;
      end else if (dangling) begin
        r.status = STATUS_DANGLING;
      end else begin
        r.status = STATUS_OK;
      end
      r.length = 16'(written);
      armed = 1'b0;
      written = 0;
      overflowed = 1'b0;
    end
    expected_runs.push_back(r);
  endfunction

  // Sender: offers the next pending byte, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(in_byte, in_last);
      end
      if (!in_valid || in_ready) begin
        if (byte_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_byte <= byte_queue[0].data;
          in_last <= byte_queue[0].last;
          void'(byte_queue.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted word against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_runs.size() == 0) begin
          flag_error($sformatf("unexpected word value=%02h run=%0d final=%b len=%0d st=%0d",
                               out_value, run_length, is_final, decoded_length, status));
        end else if ({out_value, run_length, is_final, decoded_length, status}
                     !== expected_runs[0]) begin
          flag_error($sformatf({"word mismatch: exp value=%02h run=%0d final=%b len=%0d ",
                                "st=%0d, got value=%02h run=%0d final=%b len=%0d st=%0d"},
                               expected_runs[0].value, expected_runs[0].run,
                               expected_runs[0].final_word, expected_runs[0].length,
                               expected_runs[0].status, out_value, run_length, is_final,
                               decoded_length, status));
          void'(expected_runs.pop_front());
        end else begin
          void'(expected_runs.pop_front());
        end
      end
      out_ready <= !recv_stall && ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Long receiver hold-off, counted here while the sender keeps offering bytes.
  initial begin
    wait (stall_request);
    @(posedge clk);
    recv_stall <= 1'b1;
    repeat (LONG_STALL) @(posedge clk);
    recv_stall <= 1'b0;
  end

  task automatic push_word(input logic [BYTE_W-1:0] b, input logic last);
    byte_queue.push_back('{data: b, last: last});
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (byte_queue.size() != 0 || in_valid || expected_runs.size() != 0);
    repeat (LATENCY_CYCLES) @(posedge clk);
  endtask

  // Writes the capacity register and reads it back.
  task automatic set_capacity(input logic [COUNT_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAPACITY_ADDR;
    pwdata <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    capacity_now = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    if (prdata !== APB_DW'(value)) begin
      flag_error($sformatf("capacity read back %0h, wrote %0h", prdata, value));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Queues one message: mostly well-formed runs, sometimes plain noise.
  task automatic queue_message(inout int unsigned queued);
    enc_word_t   msg[$];
    int unsigned n;
    int unsigned k;
    int unsigned pick;
    n = $urandom_range(1, 12);
    if ($urandom_range(9) == 0) begin
      for (k = 0; k < n; k++) msg.push_back('{data: 8'($urandom_range(255)), last: 1'b0});
    end else begin
      for (k = 0; k < n; k++) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          msg.push_back('{data: 8'($urandom_range(1, 255)), last: 1'b0});
        end else if (pick < 80) begin
          msg.push_back('{data: ZERO_MARKER, last: 1'b0});
          if ($urandom_range(1) == 0) begin
            msg.push_back('{data: 8'($urandom_range(1, 8)), last: 1'b0});
          end else begin
            msg.push_back('{data: 8'($urandom_range(1, 255)), last: 1'b0});
          end
        end else begin
          msg.push_back('{data: ZERO_MARKER, last: 1'b0});
          msg.push_back('{data: ZERO_MARKER, last: 1'b0});
        end
      end
    end
    // Now and then the message ends on a bare marker.
    if ($urandom_range(6) == 0) msg.push_back('{data: ZERO_MARKER, last: 1'b0});
    msg[msg.size()-1].last = 1'b1;
    foreach (msg[i]) byte_queue.push_back(msg[i]);
    queued += msg.size();
  endtask

  task automatic run_phase(input logic [COUNT_W-1:0] cap, input int unsigned n_items,
                           input logic hold_off);
    int unsigned queued;
    queued = 0;
    wait_drained();
    set_capacity(cap);
    if (hold_off) stall_request = 1'b1;
    while (queued < n_items) queue_message(queued);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Literals at both extremes, the longest run and a zero count, at the default capacity.
    push_word(8'hFF, 1'b0);
    push_word(8'h01, 1'b0);
    push_word(ZERO_MARKER, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(ZERO_MARKER, 1'b0);
    push_word(ZERO_MARKER, 1'b0);
    push_word(8'h03, 1'b1);
    // A marker alone as the last byte, then a zero count as the last byte.
    push_word(ZERO_MARKER, 1'b1);
    push_word(8'h7F, 1'b0);
    push_word(ZERO_MARKER, 1'b0);
    push_word(ZERO_MARKER, 1'b1);
    wait_drained();

    // Small capacity: a run cut short, a byte dropped, and a zero count filling it.
    set_capacity(16'd3);
    push_word(ZERO_MARKER, 1'b0);
    push_word(8'h05, 1'b0);
    push_word(8'h07, 1'b1);
    push_word(8'h41, 1'b0);
    push_word(8'h42, 1'b0);
    push_word(ZERO_MARKER, 1'b0);
    push_word(ZERO_MARKER, 1'b1);
    wait_drained();

    // Capacity lowered below what the open message has already written.
    set_capacity(CAPACITY_DEFAULT);
    push_word(8'h11, 1'b0);
    push_word(8'h22, 1'b0);
    push_word(8'h33, 1'b0);
    push_word(8'h44, 1'b0);
    wait_drained();
    set_capacity(16'd2);
    push_word(8'h55, 1'b1);
    wait_drained();

    // No room at all.
    set_capacity(16'd0);
    push_word(ZERO_MARKER, 1'b0);
    push_word(8'h09, 1'b1);

    run_phase(CAPACITY_DEFAULT, 100, 1'b0);
    run_phase(16'($urandom_range(1, 40)), 80, 1'b1);

    wait_drained();
    send_gap_pct = 70;
    recv_gap_pct = 35;
    run_phase(16'd1, 40, 1'b0);
    run_phase(16'd0, 20, 1'b0);

    wait_drained();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    run_phase(16'($urandom_range(41, 65535)), 80, 1'b0);
    run_phase(CAPACITY_DEFAULT, 80, 1'b0);

    wait_drained();
    repeat (4 * LATENCY_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_zero_run_decoder: done, clean");
    end else begin
      $display("tb_zero_run_decoder: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_zero_run_decoder: done, errors");
    $finish;
  end

endmodule
